// ===== hw/rtl/usb_command_frame_parser_macros.svh =====
// ----------------------------------------------------------------------------
// usb_command_frame_parser_macros
// Assertion macros used by the checker file.
// ----------------------------------------------------------------------------
`ifndef USB_COMMAND_FRAME_PARSER_MACROS_SVH
`define USB_COMMAND_FRAME_PARSER_MACROS_SVH
// Clocked implication with reset disable.
`define UCF_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// Next-cycle implication with reset disable.
`define UCF_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`endif

// ===== hw/rtl/ucfp_pkg.sv =====
// ----------------------------------------------------------------------------
// ucfp_pkg
// Types and constants of the command frame parser.
// ----------------------------------------------------------------------------
package ucfp_pkg;
    localparam int CHUNK_BYTES        = 65536;
    localparam int SAMPLE_LIMIT_BYTES = 33554432;
    localparam int SAMPLE_SLOT_BYTES  = 4194304;
    localparam int CHUNK_W            = $clog2(CHUNK_BYTES + 1);
    localparam int SLOT_SHIFT         = $clog2(SAMPLE_SLOT_BYTES);
    localparam int QUEUE_DEPTH        = 4;
    localparam int QUEUE_AW           = $clog2(QUEUE_DEPTH);

    localparam logic [7:0] MAGIC0    = 8'hf3;
    localparam logic [7:0] MAGIC1    = 8'h0f;
    localparam logic [7:0] MAGIC2    = 8'hab;
    localparam logic [7:0] MAGIC3_N  = 8'hca;
    localparam logic [7:0] MAGIC3_W  = 8'hcb;
    localparam logic [7:0] INFO_IDX  = 8'd64;

    localparam logic [1:0] OP_BYTE    = 2'd0;
    localparam logic [1:0] OP_TIMEOUT = 2'd1;
    localparam logic [1:0] OP_SENT    = 2'd2;

    localparam logic [1:0] EV_REPLY  = 2'd0;
    localparam logic [1:0] EV_WRITE  = 2'd1;
    localparam logic [1:0] EV_REJECT = 2'd2;
    localparam logic [1:0] EV_DATA   = 2'd3;

    localparam logic [7:0] CMD_GET_PRESET = 8'd0;
    localparam logic [7:0] CMD_SET_PRESET = 8'd1;
    localparam logic [7:0] CMD_GET_SAMPLE = 8'd2;
    localparam logic [7:0] CMD_SET_SAMPLE = 8'd3;
    localparam logic [7:0] CMD_GET_WAVE   = 8'd4;
    localparam logic [7:0] CMD_SET_WAVE   = 8'd5;
    localparam logic [7:0] CMD_COUNT      = 8'd6;

    localparam logic [1:0] REG_PRESET = 2'd0;
    localparam logic [1:0] REG_INFO   = 2'd1;
    localparam logic [1:0] REG_WAVE   = 2'd2;
    localparam logic [1:0] REG_STRIDE = 2'd3;
    localparam int CFG_W = 21;

    typedef enum logic [2:0] {
        PH_M0, PH_M1, PH_M2, PH_M3, PH_HDR, PH_DATA, PH_WAIT
    } t_phase;

    typedef struct packed {
        logic [1:0] op;
        logic [7:0] rx_byte;
    } t_in;

    typedef struct packed {
        logic [1:0]  event_res;
        logic [2:0]  reply_cmd;
        logic [7:0]  reply_index;
        logic [31:0] reply_offset;
        logic [31:0] reply_length;
        logic        reply_wide;
        logic [7:0]  payload_byte;
        logic [31:0] payload_address;
        logic        chunk_end;
        logic        last;
    } t_out;

    // Classified beat from the front end to the back end.
    typedef struct packed {
        logic        hdr_done;
        logic        data;
        logic [7:0]  cmd;
        logic [7:0]  idx;
        logic [31:0] ofs;
        logic [31:0] len;
        logic        wide;
        logic [7:0]  byte_v;
    } t_job;
endpackage

// ===== hw/rtl/ucfp_front.sv =====
// ----------------------------------------------------------------------------
// ucfp_front
// Magic hunt and header assembly; hands finished headers and payload bytes on.
// ----------------------------------------------------------------------------
module ucfp_front (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  ucfp_pkg::t_in   i_in,
    input  logic            i_fire,
    input  logic            i_hdr_ok_data, // header opened a payload phase
    input  logic            i_hdr_ok_wait, // header opened a send-done wait
    input  logic            i_data_last,   // payload byte ends the transfer
    output ucfp_pkg::t_phase o_phase_next,
    output logic [7:0]      o_idx,         // index byte of the header in progress
    output ucfp_pkg::t_job  o_job,
    output logic            o_job_valid
);
    ucfp_pkg::t_phase r_phase, n_phase;
    logic        r_wide, n_wide;
    logic [3:0]  r_cnt, n_cnt;
    logic [7:0]  r_cmd, n_cmd, r_idx, n_idx;
    logic [31:0] r_ofs, n_ofs, r_len, n_len;
    logic [2:0]  k;
    logic [2:0]  w;
    logic [3:0]  cnt1;
    logic [7:0]  b;

    assign b = i_in.rx_byte;
    assign w = r_wide ? 3'd4 : 3'd2;
    assign k = 3'(r_cnt - 4'd2);
    assign cnt1 = r_cnt + 4'd1;

    always_comb begin
        n_phase = r_phase; n_wide = r_wide; n_cnt = r_cnt;
        n_cmd = r_cmd; n_idx = r_idx; n_ofs = r_ofs; n_len = r_len;
        o_job = '0;
        o_job_valid = 1'b0;
        if (i_fire) begin
            if (i_in.op == ucfp_pkg::OP_TIMEOUT) begin
                n_phase = ucfp_pkg::PH_M0;
            end else if (i_in.op == ucfp_pkg::OP_SENT) begin
                if (r_phase == ucfp_pkg::PH_WAIT) n_phase = ucfp_pkg::PH_M0;
            end else if (i_in.op == ucfp_pkg::OP_BYTE) begin
                case (r_phase)
                    ucfp_pkg::PH_M0: n_phase = (b == ucfp_pkg::MAGIC0) ?
                        ucfp_pkg::PH_M1 : ucfp_pkg::PH_M0;
                    ucfp_pkg::PH_M1: n_phase = (b == ucfp_pkg::MAGIC1) ? ucfp_pkg::PH_M2 :
                        (b == ucfp_pkg::MAGIC0) ? ucfp_pkg::PH_M1 : ucfp_pkg::PH_M0;
                    ucfp_pkg::PH_M2: n_phase = (b == ucfp_pkg::MAGIC2) ? ucfp_pkg::PH_M3 :
                        (b == ucfp_pkg::MAGIC0) ? ucfp_pkg::PH_M1 : ucfp_pkg::PH_M0;
                    ucfp_pkg::PH_M3: begin
                        if (b == ucfp_pkg::MAGIC3_N || b == ucfp_pkg::MAGIC3_W) begin
                            n_phase = ucfp_pkg::PH_HDR;
                            n_wide = (b == ucfp_pkg::MAGIC3_W);
                            n_cnt = '0; n_cmd = '0; n_idx = '0; n_ofs = '0; n_len = '0;
                        end else begin
                            n_phase = (b == ucfp_pkg::MAGIC0) ?
                                ucfp_pkg::PH_M1 : ucfp_pkg::PH_M0;
                        end
                    end
                    ucfp_pkg::PH_HDR: begin
                        if (r_cnt == 4'd0) n_cmd = b;
                        else if (r_cnt == 4'd1) n_idx = b;
                        else if (k < w) n_ofs = r_ofs | (32'(b) << {k[1:0], 3'b000});
                        else n_len = r_len | (32'(b) << {2'(k - w), 3'b000});
                        n_cnt = cnt1;
                        if (cnt1 == 4'(4'd2 + 4'(w) * 4'd2)) begin
                            o_job_valid = 1'b1;
                            o_job.hdr_done = 1'b1;
                            o_job.cmd = n_cmd; o_job.idx = n_idx;
                            o_job.ofs = n_ofs; o_job.len = n_len; o_job.wide = r_wide;
                            n_phase = i_hdr_ok_data ? ucfp_pkg::PH_DATA :
                                i_hdr_ok_wait ? ucfp_pkg::PH_WAIT : ucfp_pkg::PH_M0;
                        end
                    end
                    ucfp_pkg::PH_DATA: begin
                        o_job_valid = 1'b1;
                        o_job.data = 1'b1;
                        o_job.byte_v = b;
                        if (i_data_last) n_phase = ucfp_pkg::PH_M0;
                    end
                    default: ;
                endcase
            end
        end
    end

    assign o_phase_next = n_phase;
    assign o_idx = r_idx;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= ucfp_pkg::PH_M0;
            r_wide <= 1'b0; r_cnt <= '0;
        end else begin
            r_phase <= n_phase; r_wide <= n_wide; r_cnt <= n_cnt;
        end
        r_cmd <= n_cmd; r_idx <= n_idx; r_ofs <= n_ofs; r_len <= n_len;
    end
endmodule

// ===== hw/rtl/ucfp_decide.sv =====
// ----------------------------------------------------------------------------
// ucfp_decide
// Header checks and payload bookkeeping; turns a classified beat into a result.
// ----------------------------------------------------------------------------
module ucfp_decide (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_fire,
    input  logic                     i_clear,
    input  ucfp_pkg::t_job           i_job,
    input  logic                     i_job_valid,
    input  logic [15:0]              i_preset,
    input  logic [15:0]              i_info,
    input  logic [ucfp_pkg::CFG_W-1:0] i_wave,
    input  logic [31:0]              i_wave_base, // index times stride, precomputed
    output logic                     o_hdr_ok_data,
    output logic                     o_hdr_ok_wait,
    output logic                     o_data_last,
    output ucfp_pkg::t_out           o_res,
    output logic                     o_res_valid
);
    logic [7:0]  r_cmd, r_idx;
    logic [31:0] r_left, r_addr;
    logic [ucfp_pkg::CHUNK_W-1:0] r_chunk;
    logic [32:0] sum, lim;
    logic        bad;
    logic [31:0] left1, base;
    logic [ucfp_pkg::CHUNK_W-1:0] chunk1;
    logic [7:0]  c;

    assign c = i_job.cmd;

    always_comb begin
        if (c == ucfp_pkg::CMD_GET_SAMPLE || c == ucfp_pkg::CMD_SET_SAMPLE)
            lim = 33'(ucfp_pkg::SAMPLE_LIMIT_BYTES);
        else if (c == ucfp_pkg::CMD_GET_WAVE || c == ucfp_pkg::CMD_SET_WAVE)
            lim = 33'(i_wave);
        else
            lim = (i_job.idx >= ucfp_pkg::INFO_IDX) ? 33'(i_info) : 33'(i_preset);
        sum = 33'(i_job.ofs) + 33'(i_job.len);
        bad = (c >= ucfp_pkg::CMD_COUNT) || (sum > lim) ||
              (c == ucfp_pkg::CMD_SET_PRESET && i_job.idx >= ucfp_pkg::INFO_IDX);
        if (c == ucfp_pkg::CMD_SET_SAMPLE)
            base = i_job.ofs + (32'(i_job.idx) << ucfp_pkg::SLOT_SHIFT);
        else if (c == ucfp_pkg::CMD_SET_WAVE)
            base = i_job.ofs + i_wave_base;
        else
            base = i_job.ofs;
        left1 = r_left - 32'd1;
        chunk1 = (r_chunk != '0) ? r_chunk - 1'b1 : r_chunk;
    end

    assign o_hdr_ok_data = !bad && i_job.len != '0 && c[0];
    assign o_hdr_ok_wait = !bad && !c[0];
    assign o_data_last = (left1 == '0);

    always_comb begin
        o_res = '0;
        o_res_valid = i_job_valid;
        if (i_job.hdr_done) begin
            if (bad) begin
                o_res.event_res = ucfp_pkg::EV_REJECT;
            end else if (!c[0]) begin
                o_res.event_res = ucfp_pkg::EV_REPLY;
                o_res.reply_cmd = 3'(c + 8'd1);
                o_res.reply_index = (c == ucfp_pkg::CMD_GET_SAMPLE) ?
                    (i_job.idx & 8'd7) : i_job.idx;
                o_res.reply_offset = i_job.ofs;
                o_res.reply_length = i_job.len;
                o_res.reply_wide = (c == ucfp_pkg::CMD_GET_PRESET) ? i_job.wide : 1'b1;
                if (c == ucfp_pkg::CMD_GET_PRESET && i_job.len == '0) begin
                    o_res.reply_length = 32'(lim) - i_job.ofs;
                    o_res.reply_wide = 1'b0;
                end
            end else begin
                o_res.event_res = ucfp_pkg::EV_WRITE;
                o_res.reply_cmd = 3'(c);
                o_res.reply_index = i_job.idx;
                o_res.reply_offset = i_job.ofs;
                o_res.reply_length = i_job.len;
                o_res.reply_wide = (c == ucfp_pkg::CMD_SET_SAMPLE) ? 1'b1 : i_job.wide;
            end
        end else begin
            o_res.event_res = ucfp_pkg::EV_DATA;
            o_res.reply_cmd = 3'(r_cmd);
            o_res.reply_index = r_idx;
            o_res.payload_byte = i_job.byte_v;
            o_res.payload_address = r_addr;
            o_res.chunk_end = (r_cmd == ucfp_pkg::CMD_SET_SAMPLE) && (chunk1 == '0);
            o_res.last = o_data_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_clear) begin
            r_cmd <= '0; r_idx <= '0; r_left <= '0; r_addr <= '0; r_chunk <= '0;
        end else if (i_fire && i_job_valid) begin
            if (i_job.hdr_done) begin
                r_cmd <= c; r_idx <= i_job.idx; r_left <= i_job.len; r_addr <= base;
                r_chunk <= (i_job.len > 32'(ucfp_pkg::CHUNK_BYTES)) ?
                    ucfp_pkg::CHUNK_W'(ucfp_pkg::CHUNK_BYTES) :
                    ucfp_pkg::CHUNK_W'(i_job.len);
            end else begin
                r_left <= left1;
                r_addr <= r_addr + 32'd1;
                if (chunk1 == '0 && left1 != '0)
                    r_chunk <= (left1 > 32'(ucfp_pkg::CHUNK_BYTES)) ?
                        ucfp_pkg::CHUNK_W'(ucfp_pkg::CHUNK_BYTES) :
                        ucfp_pkg::CHUNK_W'(left1);
                else
                    r_chunk <= chunk1;
            end
        end
    end
endmodule

// ===== hw/rtl/ucfp_queue.sv =====
// ----------------------------------------------------------------------------
// ucfp_queue
// Short result queue between the parser and the output channel.
// ----------------------------------------------------------------------------
module ucfp_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  ucfp_pkg::t_out i_data,
    input  logic           i_pop,
    output ucfp_pkg::t_out o_data,
    output logic           o_valid,
    output logic           o_full
);
    ucfp_pkg::t_out r_mem [ucfp_pkg::QUEUE_DEPTH];
    logic [ucfp_pkg::QUEUE_AW-1:0] r_wp, r_rp;
    logic [ucfp_pkg::QUEUE_AW:0]   r_cnt;

    assign o_valid = (r_cnt != '0);
    assign o_full  = (r_cnt == (ucfp_pkg::QUEUE_AW+1)'(ucfp_pkg::QUEUE_DEPTH));
    assign o_data  = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wp] <= i_data;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp <= '0; r_rp <= '0; r_cnt <= '0;
        end else begin
            if (i_push) r_wp <= r_wp + 1'b1;
            if (i_pop)  r_rp <= r_rp + 1'b1;
            r_cnt <= r_cnt + (ucfp_pkg::QUEUE_AW+1)'(i_push)
                           - (ucfp_pkg::QUEUE_AW+1)'(i_pop);
        end
    end
endmodule

// ===== hw/rtl/usb_command_frame_parser.sv =====
// ----------------------------------------------------------------------------
// usb_command_frame_parser
// Result: a result beat is in the output queue in the cycle after its byte beat is taken.
// Throughput: one input beat per cycle; the queue of four result beats
// stalls input only while it is full.
// Reset: synchronous active low; returns to magic hunt, configuration registers to defaults.
// ----------------------------------------------------------------------------
// Command frame parser for a USB byte stream. The front end hunts for the
// magic and gathers header bytes. The decide stage checks the finished
// header against its command's limit and tags payload bytes with their
// address. Results sit in a short queue so the input keeps flowing while
// the consumer stalls, until the queue is full.
module usb_command_frame_parser (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_valid,
    output logic                      o_stall,
    input  ucfp_pkg::t_in             i_data,
    output logic                      o_valid,
    input  logic                      i_stall,
    output ucfp_pkg::t_out            o_data,
    input  logic                      i_cfg_we,
    input  logic [1:0]                i_cfg_index,
    input  logic [ucfp_pkg::CFG_W-1:0] i_cfg_data
);
    logic [15:0] r_preset, r_info, r_stride;
    logic [ucfp_pkg::CFG_W-1:0] r_wave;
    logic [31:0] r_wave_base;
    logic [7:0]  hdr_idx;
    logic        fire, full, clear;
    logic        hdr_ok_data, hdr_ok_wait, data_last, job_valid, res_valid;
    ucfp_pkg::t_job job;
    ucfp_pkg::t_out res;
    ucfp_pkg::t_phase phase_next;

    // Stall only while the queue has no room for the beat's possible result.
    assign o_stall = full;
    assign fire = i_valid && !full;
    assign clear = fire && (i_data.op == ucfp_pkg::OP_TIMEOUT);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_preset <= 16'd1552; r_info <= 16'd64;
            r_wave <= ucfp_pkg::CFG_W'(35054); r_stride <= 16'd2062;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                ucfp_pkg::REG_PRESET: r_preset <= i_cfg_data[15:0];
                ucfp_pkg::REG_INFO:   r_info   <= i_cfg_data[15:0];
                ucfp_pkg::REG_WAVE:   r_wave   <= i_cfg_data;
                ucfp_pkg::REG_STRIDE: r_stride <= i_cfg_data[15:0];
                default: ;
            endcase
        end
    end

    // The index byte is the second header byte, so the stride product is
    // registered well before the header's last byte arrives.
    always_ff @(posedge i_clk) begin
        r_wave_base <= 32'(hdr_idx) * 32'(r_stride);
    end

    ucfp_front u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_in(i_data), .i_fire(fire),
        .i_hdr_ok_data(hdr_ok_data), .i_hdr_ok_wait(hdr_ok_wait),
        .i_data_last(data_last), .o_phase_next(phase_next), .o_idx(hdr_idx),
        .o_job(job), .o_job_valid(job_valid)
    );

    ucfp_decide u_decide (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_fire(fire), .i_clear(clear),
        .i_job(job), .i_job_valid(job_valid), .i_preset(r_preset), .i_info(r_info),
        .i_wave(r_wave), .i_wave_base(r_wave_base), .o_hdr_ok_data(hdr_ok_data),
        .o_hdr_ok_wait(hdr_ok_wait), .o_data_last(data_last),
        .o_res(res), .o_res_valid(res_valid)
    );

    ucfp_queue u_queue (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_push(fire && res_valid), .i_data(res),
        .i_pop(o_valid && !i_stall), .o_data(o_data), .o_valid(o_valid), .o_full(full)
    );
endmodule

// ===== hw/rtl/ucfp_checker.sv =====
// ----------------------------------------------------------------------------
// ucfp_checker
// Port-level checks of the command frame parser.
// ----------------------------------------------------------------------------
`include "usb_command_frame_parser_macros.svh"
module ucfp_checker (
    input logic           i_clk,
    input logic           i_rst_n,
    input logic           o_valid,
    input logic           i_stall,
    input ucfp_pkg::t_out o_data
);
    `UCF_ASSERT_NEXT(a_hold, i_clk, i_rst_n, o_valid && i_stall, o_valid && $stable(o_data), "stalled result changed")
    `UCF_ASSERT_IMP(a_rej, i_clk, i_rst_n, o_valid && o_data.event_res == ucfp_pkg::EV_REJECT, o_data.reply_cmd == '0 && o_data.payload_address == '0, "reject beat has fields")
    `UCF_ASSERT_IMP(a_ce, i_clk, i_rst_n, o_valid && o_data.chunk_end, o_data.event_res == ucfp_pkg::EV_DATA && o_data.reply_cmd == 3'd3, "chunk end outside sample write")
endmodule

bind usb_command_frame_parser ucfp_checker u_chk (
    .i_clk(i_clk), .i_rst_n(i_rst_n), .o_valid(o_valid), .i_stall(i_stall), .o_data(o_data)
);
